// ===== hdl/ssc_pkg.sv =====
package ssc_pkg;

	localparam int MAX_RANKS = 64;
	localparam int POS_W     = 6;
	localparam int COUNT_W   = 7;
	localparam int STEP_W    = 3;
	localparam int ROLE_W    = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 7;

	localparam logic [ROLE_W-1:0] ROLE_IDLE    = 2'd0;
	localparam logic [ROLE_W-1:0] ROLE_SEND    = 2'd1;
	localparam logic [ROLE_W-1:0] ROLE_RECEIVE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_RANK_COUNT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MY_POSITION   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROOT_POSITION = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT    = 2'd3;

	localparam logic [STEP_W-1:0] MOD_TOP_BIT = STEP_W'(POS_W - 1);

	typedef struct packed {
		logic              capture;
		logic              mod_iter;
		logic              mod_root;
		logic              mod_last;
		logic [STEP_W-1:0] mod_bit;
		logic              plan;
		logic              advance;
	} ssc_cmd_t;

	typedef struct packed {
		logic last_word;
	} ssc_status_t;

endpackage

// ===== hdl/scatter_step_schedule.sv =====
// channel   handshake                    payload
// request   start, busy                  step_number
// result    result_strobe                role, peer_position, slice_index, slice_total, last
// config    cfg_valid, cfg_ready         cfg_index, cfg_data
//
// A request is taken when start is high and busy low. Two remainder passes
// reduce my and root positions modulo the ring size, a plan step follows,
// then one result word per cycle, 1 to 32 words per request.
// The receiver cannot stall; each word shows for one cycle under result_strobe.
// Reset is asynchronous and active low; config returns to its reset values.
module scatter_step_schedule (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [ssc_pkg::STEP_W-1:0]    step_number,
	output logic                          result_strobe,
	output logic [ssc_pkg::ROLE_W-1:0]    role,
	output logic [ssc_pkg::POS_W-1:0]     peer_position,
	output logic [ssc_pkg::POS_W-1:0]     slice_index,
	output logic [ssc_pkg::POS_W-1:0]     slice_total,
	output logic                          last,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ssc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ssc_pkg::CFG_W-1:0]     cfg_data
);
	import ssc_pkg::*;

	ssc_cmd_t    cmd;
	ssc_status_t status;

	assign cfg_ready = 1'b1;

	ssc_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.status        (status),
		.cmd           (cmd),
		.busy          (busy),
		.result_strobe (result_strobe)
	);

	ssc_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.step_number   (step_number),
		.cmd           (cmd),
		.status        (status),
		.role          (role),
		.peer_position (peer_position),
		.slice_index   (slice_index),
		.slice_total   (slice_total),
		.last          (last)
	);

endmodule

// ===== hdl/ssc_datapath.sv =====
module ssc_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	input  logic [ssc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ssc_pkg::CFG_W-1:0]     cfg_data,
	input  logic [ssc_pkg::STEP_W-1:0]    step_number,
	input  ssc_pkg::ssc_cmd_t             cmd,
	output ssc_pkg::ssc_status_t          status,
	output logic [ssc_pkg::ROLE_W-1:0]    role,
	output logic [ssc_pkg::POS_W-1:0]     peer_position,
	output logic [ssc_pkg::POS_W-1:0]     slice_index,
	output logic [ssc_pkg::POS_W-1:0]     slice_total,
	output logic                          last
);
	import ssc_pkg::*;

	logic [COUNT_W-1:0] rank_count_q;
	logic [POS_W-1:0]   my_position_q;
	logic [POS_W-1:0]   root_position_q;
	logic [STEP_W-1:0]  step_count_q;

	logic [STEP_W-1:0]  step_q;
	logic [POS_W-1:0]   rem_q;
	logic [POS_W-1:0]   me_q;
	logic [POS_W-1:0]   root_q;

	logic [ROLE_W-1:0]  role_q;
	logic [POS_W-1:0]   peer_q;
	logic [POS_W-1:0]   idx_q;
	logic [POS_W-1:0]   total_q;
	logic [POS_W-1:0]   back_q;
	logic [POS_W-1:0]   remain_q;

	logic [COUNT_W-1:0] n;
	logic               op_bit;
	logic [COUNT_W-1:0] rem_try;
	logic [POS_W-1:0]   rem_next;

	logic [7:0]         pair;
	logic [8:0]         dslice;
	logic [7:0]         span;
	logic [8:0]         slices_w;
	logic [POS_W-1:0]   slices;
	logic [COUNT_W-1:0] droot_try;
	logic [POS_W-1:0]   droot;
	logic               perfect;
	logic               last_step;
	logic [7:0]         active;
	logic               is_send;
	logic               is_recv;
	logic [7:0]         peer_send_try;
	logic [7:0]         peer_recv_try;
	logic [POS_W-1:0]   peer_send;
	logic [POS_W-1:0]   peer_recv;
	logic [POS_W-1:0]   back;
	logic [COUNT_W-1:0] idx_try;
	logic [POS_W-1:0]   idx_next;

	// clamp the ring size into the supported range
	always_comb begin
		if (rank_count_q < COUNT_W'(2)) begin
			n = COUNT_W'(2);
		end else if (rank_count_q > COUNT_W'(MAX_RANKS)) begin
			n = COUNT_W'(MAX_RANKS);
		end else begin
			n = rank_count_q;
		end
	end

	// one restoring remainder step per cycle
	always_comb begin
		op_bit   = cmd.mod_root ? root_position_q[cmd.mod_bit] : my_position_q[cmd.mod_bit];
		rem_try  = {rem_q, op_bit};
		rem_next = (rem_try >= n) ? POS_W'(rem_try - n) : POS_W'(rem_try);
	end

	always_comb begin
		pair      = 8'd1 << step_q;
		dslice    = 9'd1 << step_q;
		dslice    = dslice << 1;
		span      = 8'(n) - 8'd1 + pair;
		slices_w  = 9'(span) >> (4'(step_q) + 4'd1);
		slices    = slices_w[POS_W-1:0];

		droot_try = COUNT_W'(root_q) + n - COUNT_W'(me_q);
		droot     = (droot_try >= n) ? POS_W'(droot_try - n) : POS_W'(droot_try);

		perfect   = (n & (n - COUNT_W'(1))) == '0;
		last_step = (step_count_q != '0) && (step_q == step_count_q - STEP_W'(1));
		if (!perfect && last_step) begin
			active = (8'(n) >= pair) ? 8'(n) - pair : 8'd0;
		end else begin
			active = pair;
		end

		is_send = (slices != '0) && (8'(droot) < active);
		is_recv = (slices != '0) && !is_send && (8'(droot) >= pair)
			&& (9'(droot) < 9'(active) + 9'(pair));

		// a live role implies pair below n, so one subtract reduces each sum
		peer_send_try = 8'(me_q) + 8'(n) - pair;
		peer_send     = (peer_send_try >= 8'(n)) ? POS_W'(peer_send_try - 8'(n))
			: POS_W'(peer_send_try);
		peer_recv_try = 8'(me_q) + pair;
		peer_recv     = (peer_recv_try >= 8'(n)) ? POS_W'(peer_recv_try - 8'(n))
			: POS_W'(peer_recv_try);
		back          = (dslice >= 9'(n)) ? POS_W'(dslice - 9'(n)) : POS_W'(dslice);

		idx_try  = COUNT_W'(idx_q) + n - COUNT_W'(back_q);
		idx_next = (idx_try >= n) ? POS_W'(idx_try - n) : POS_W'(idx_try);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_count_q    <= COUNT_W'(2);
			my_position_q   <= '0;
			root_position_q <= '0;
			step_count_q    <= STEP_W'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_RANK_COUNT:    rank_count_q    <= cfg_data;
				CFG_MY_POSITION:   my_position_q   <= cfg_data[POS_W-1:0];
				CFG_ROOT_POSITION: root_position_q <= cfg_data[POS_W-1:0];
				CFG_STEP_COUNT:    step_count_q    <= cfg_data[STEP_W-1:0];
				default:           ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			step_q <= step_number;
			rem_q  <= '0;
		end else if (cmd.mod_iter) begin
			if (cmd.mod_last) begin
				rem_q <= '0;
				if (cmd.mod_root) begin
					root_q <= rem_next;
				end else begin
					me_q <= rem_next;
				end
			end else begin
				rem_q <= rem_next;
			end
		end

		if (cmd.plan) begin
			back_q <= back;
			if (is_send) begin
				role_q   <= ROLE_SEND;
				peer_q   <= peer_send;
				idx_q    <= peer_send;
				total_q  <= slices;
				remain_q <= slices;
			end else if (is_recv) begin
				role_q   <= ROLE_RECEIVE;
				peer_q   <= peer_recv;
				idx_q    <= me_q;
				total_q  <= slices;
				remain_q <= slices;
			end else begin
				role_q   <= ROLE_IDLE;
				peer_q   <= '0;
				idx_q    <= '0;
				total_q  <= '0;
				remain_q <= POS_W'(1);
			end
		end else if (cmd.advance) begin
			idx_q    <= idx_next;
			remain_q <= remain_q - POS_W'(1);
		end
	end

	assign status.last_word = (remain_q == POS_W'(1));

	assign role          = role_q;
	assign peer_position = peer_q;
	assign slice_index   = idx_q;
	assign slice_total   = total_q;
	assign last          = status.last_word;

endmodule

// ===== hdl/ssc_ctrl.sv =====
module ssc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  ssc_pkg::ssc_status_t status,
	output ssc_pkg::ssc_cmd_t    cmd,
	output logic                 busy,
	output logic                 result_strobe
);
	import ssc_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE     = 5'b00001,
		S_MOD_ME   = 5'b00010,
		S_MOD_ROOT = 5'b00100,
		S_PLAN     = 5'b01000,
		S_EMIT     = 5'b10000
	} state_t;

	state_t            state_q;
	state_t            state_d;
	logic [STEP_W-1:0] bit_q;
	logic [STEP_W-1:0] bit_d;

	always_comb begin
		state_d      = state_q;
		bit_d        = bit_q;
		cmd          = '0;
		cmd.mod_bit  = bit_q;
		cmd.mod_last = (bit_q == '0);
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					bit_d       = MOD_TOP_BIT;
					state_d     = S_MOD_ME;
				end
			end
			S_MOD_ME: begin
				cmd.mod_iter = 1'b1;
				if (bit_q == '0) begin
					bit_d   = MOD_TOP_BIT;
					state_d = S_MOD_ROOT;
				end else begin
					bit_d = bit_q - STEP_W'(1);
				end
			end
			S_MOD_ROOT: begin
				cmd.mod_iter = 1'b1;
				cmd.mod_root = 1'b1;
				if (bit_q == '0) begin
					state_d = S_PLAN;
				end else begin
					bit_d = bit_q - STEP_W'(1);
				end
			end
			S_PLAN: begin
				cmd.plan = 1'b1;
				state_d  = S_EMIT;
			end
			S_EMIT: begin
				cmd.advance = 1'b1;
				// drop back to idle after the final word
				if (status.last_word) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			bit_q   <= '0;
		end else begin
			state_q <= state_d;
			bit_q   <= bit_d;
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign result_strobe = (state_q == S_EMIT);

endmodule

// ===== tb/sv/scatter_step_schedule_tb.sv =====
module scatter_step_schedule_tb;
	import ssc_pkg::*;

	typedef struct {
		logic [ROLE_W-1:0] role;
		logic [POS_W-1:0]  peer;
		logic [POS_W-1:0]  slice;
		logic [POS_W-1:0]  total;
		logic              last;
	} step_word_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [STEP_W-1:0]    step_number = '0;
	logic                 result_strobe;
	logic [ROLE_W-1:0]    role;
	logic [POS_W-1:0]     peer_position;
	logic [POS_W-1:0]     slice_index;
	logic [POS_W-1:0]     slice_total;
	logic                 last;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	// register copies as the block should hold them
	logic [COUNT_W-1:0] ring_size_reg = 7'd2;
	logic [POS_W-1:0]   my_pos_reg = '0;
	logic [POS_W-1:0]   root_pos_reg = '0;
	logic [STEP_W-1:0]  steps_reg = 3'd1;

	step_word_t due_words[$];
	int         idle_pct = 0;
	int         fail_count = 0;
	int         steps_issued = 0;
	int         words_seen = 0;
	int         settings_applied = 0;

	scatter_step_schedule u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.step_number   (step_number),
		.result_strobe (result_strobe),
		.role          (role),
		.peer_position (peer_position),
		.slice_index   (slice_index),
		.slice_total   (slice_total),
		.last          (last),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// work out every word one step request should produce and queue them
	function automatic void plan_step_words(input logic [STEP_W-1:0] step);
		int         n, me, root, pair, dslice, slices, droot, active, peer, idx, back, i;
		bit         perfect, last_step;
		logic [ROLE_W-1:0] r;
		step_word_t w;
		n = int'(ring_size_reg);
		if (n < 2) n = 2;
		if (n > MAX_RANKS) n = MAX_RANKS;
		me = int'(my_pos_reg) % n;
		root = int'(root_pos_reg) % n;
		pair = 1 << step;
		dslice = 1 << (step + 1);
		slices = (n - 1 + pair) / dslice;
		droot = (root + n - me) % n;
		perfect = (n & (n - 1)) == 0;
		last_step = int'(steps_reg) != 0 && int'(step) == int'(steps_reg) - 1;
		if (!perfect && last_step)
			active = (n >= pair) ? n - pair : 0;
		else
			active = pair;
		r = ROLE_IDLE;
		peer = 0;
		idx = 0;
		if (slices != 0) begin
			if (droot < active) begin
				r = ROLE_SEND;
				peer = (me + n - (pair % n)) % n;
				idx = peer;
			end else if (droot >= pair && droot < active + pair) begin
				r = ROLE_RECEIVE;
				peer = (me + pair) % n;
				idx = me;
			end
		end
		if (r == ROLE_IDLE) begin
			w = '{ROLE_IDLE, '0, '0, '0, 1'b1};
			due_words = {due_words, w};
			return;
		end
		back = dslice % n;
		for (i = 0; i < slices && i < 32; i++) begin
			w.role = r;
			w.peer = POS_W'(peer);
			w.slice = POS_W'(idx);
			w.total = POS_W'(slices);
			w.last = (i + 1 == slices);
			due_words = {due_words, w};
			idx = (idx + n - back) % n;
		end
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= 40)
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		step_word_t want;
		if (arst_n && result_strobe) begin
			words_seen++;
			if (due_words.size() == 0) begin
				fail_count++;
				if (fail_count <= 40)
					$display("%0t: word with nothing expected, got role %0d peer %0d slice %0d",
						$time, role, peer_position, slice_index);
			end else begin
				want = due_words.pop_front();
				check_field("role", 8'(want.role), 8'(role));
				check_field("peer_position", 8'(want.peer), 8'(peer_position));
				check_field("slice_index", 8'(want.slice), 8'(slice_index));
				check_field("slice_total", 8'(want.total), 8'(slice_total));
				check_field("last", 8'(want.last), 8'(last));
			end
		end
	end

	// hold start until the request is taken; leave it high for a following word
	task automatic issue_step(input int s);
		int gap;
		if ($urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 24);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		step_number <= STEP_W'(s);
		do @(posedge clk); while (busy);
		plan_step_words(STEP_W'(s));
		steps_issued++;
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (due_words.size() != 0 || busy) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_RANK_COUNT:    ring_size_reg = val;
			CFG_MY_POSITION:   my_pos_reg = val[POS_W-1:0];
			CFG_ROOT_POSITION: root_pos_reg = val[POS_W-1:0];
			CFG_STEP_COUNT:    steps_reg = val[STEP_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_setting(input int ranks, input int mine, input int root,
			input int steps);
		wait_idle();
		write_reg(CFG_RANK_COUNT, CFG_W'(ranks));
		write_reg(CFG_MY_POSITION, CFG_W'(mine));
		write_reg(CFG_ROOT_POSITION, CFG_W'(root));
		write_reg(CFG_STEP_COUNT, CFG_W'(steps));
		cfg_valid <= 1'b0;
		settings_applied++;
	endtask

	task automatic random_setting();
		int n, ranks, lg;
		if ($urandom_range(0, 4) == 0)
			ranks = $urandom_range(0, 127);
		else
			ranks = $urandom_range(2, 64);
		n = (ranks < 2) ? 2 : (ranks > MAX_RANKS) ? MAX_RANKS : ranks;
		lg = 0;
		while ((1 << lg) < n) lg++;
		if ($urandom_range(0, 4) == 0)
			lg = $urandom_range(0, 7);
		// spare top bit of the position words is set now and then; it must be dropped
		apply_setting(ranks, int'($urandom_range(0, 127)), int'($urandom_range(0, 127)), lg);
	endtask

	task automatic test_reset_state();
		issue_step(0);
		issue_step(1);
		issue_step(7);
	endtask

	task automatic test_directed();
		apply_setting(64, 0, 0, 6);
		issue_step(0);
		issue_step(5);
		apply_setting(64, 32, 0, 6);
		issue_step(5);
		issue_step(0);
		apply_setting(127, 63, 1, 6);
		issue_step(1);
		// ring clamped up to two, zero step count, positions folded into the ring
		apply_setting(0, 5, 0, 0);
		issue_step(0);
		issue_step(6);
		// odd ring: active count shrinks on the last step
		apply_setting(5, 63, 62, 3);
		issue_step(0);
		issue_step(1);
		issue_step(2);
		issue_step(7);
		apply_setting(5, 0, 0, 4);
		issue_step(3);
		apply_setting(63, 10, 17, 6);
		for (int k = 0; k < 6; k++) issue_step(k);
	endtask

	task automatic test_random_steps(input int pct, input int count);
		int sent, k;
		idle_pct = pct;
		sent = 0;
		while (sent < count) begin
			random_setting();
			for (k = 0; k < int'(steps_reg) && sent < count; k++) begin
				issue_step(k);
				sent++;
			end
			if ($urandom_range(0, 3) == 0 && sent < count) begin
				issue_step(int'($urandom_range(0, 7)));
				sent++;
			end
		end
	endtask

	task automatic test_drain_between();
		int k;
		random_setting();
		for (k = 0; k < 6; k++) begin
			issue_step(int'($urandom_range(0, 7)));
			wait_idle();
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_directed();
		test_random_steps(29, 61);
		test_random_steps(70, 61);
		test_random_steps(0, 61);
		test_drain_between();
		wait_idle();
		repeat (60) @(posedge clk);
		if (due_words.size() != 0) begin
			fail_count++;
			$display("%0t: %0d words never arrived", $time, due_words.size());
		end
		$display("Ran %0d step requests over %0d register settings, %0d result words seen.",
			steps_issued, settings_applied, words_seen);
		$display("Covered clamped and folded rings, odd last steps, idle and back-to-back requests.");
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#5000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/ssc_pkg.sv
hdl/ssc_datapath.sv
hdl/ssc_ctrl.sv
hdl/scatter_step_schedule.sv
tb/sv/scatter_step_schedule_tb.sv
